@@ src/image_mask_correlate_convolve_top_defines.svh @@
// Assertion macros shared by the image mask correlate/convolve RTL.
// Needs clk and rst in the scope of each use; no other dependencies.
`ifndef IMAGE_MASK_CORRELATE_CONVOLVE_TOP_DEFINES_SVH
`define IMAGE_MASK_CORRELATE_CONVOLVE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define IMCC_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("imcc assertion failed");
`define IMCC_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("imcc assertion failed");
`else
`define IMCC_ASSERT_IMP(lbl, a, b)
`define IMCC_ASSERT_NXT(lbl, a, b)
`endif

`endif

@@ src/imcc_pkg.sv @@
// Shared constants, op codes, register indexes and control structs for the
// image mask correlate/convolve block. No dependencies.
package imcc_pkg;

  localparam int MASK_SIZE  = 3;
  localparam int MASK_LEN   = MASK_SIZE * MASK_SIZE;
  localparam int MASK_HALF  = MASK_SIZE / 2;
  localparam int MAX_ROWS   = 256;
  localparam int MAX_COLS   = 256;
  localparam int PIXEL_BITS = 8;

  localparam int OP_W    = 2;
  localparam int ROW_W   = 8;
  localparam int COL_W   = 8;
  localparam int PIX_W   = 8;
  localparam int CIDX_W  = 6;
  localparam int COEF_W  = 16;
  localparam int CNT_W   = 9;
  localparam int OUT_W   = 32;
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int TAP_W   = (MASK_SIZE > 1) ? $clog2(MASK_SIZE) : 1;
  localparam int KW      = (MASK_LEN > 1) ? $clog2(MASK_LEN) : 1;
  localparam int SW      = ROW_W + 2;
  localparam int PROD_W  = COEF_W + PIXEL_BITS + 1;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_COEF = 2'd0,
    OP_WRITE_PIX = 2'd1,
    OP_COMPUTE   = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_MIRROR = 2'd2;

  typedef struct packed {
    logic             coef_we;
    logic             pix_we;
    logic             capture;
    logic             issue;
    logic             first;
    logic             last;
    logic [TAP_W-1:0] tap_r;
    logic [TAP_W-1:0] tap_c;
  } imcc_cmd_t;

  typedef struct packed {
    logic drain_done;
  } imcc_stat_t;

endpackage

@@ src/image_mask_correlate_convolve_top.sv @@
// Top level: APB register file, controller and datapath of the mask filter.
// Depends on imcc_pkg, imcc_ctrl and imcc_datapath.
//
//   channel   direction  handshake                    fields
//   item      in         start && !busy               op pix_row pix_col pixel_value
//                                                     coef_index coef_value
//   result    out        result_valid (1 cycle)       out_row out_col filtered
//   config    in/out     psel penable pwrite pready   paddr pwdata prdata
//
// Coefficient loads and pixel writes do not raise busy; busy stays low.
// A compute transaction holds busy for one frame memory read per tap, then read,
// multiply and accumulate drain; the result strobe rises in the same cycle that
// busy falls.
// Reset clears state, config and valid flags; memories and data are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module image_mask_correlate_convolve_top
  import imcc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          op,
  input  logic [ROW_W-1:0]         pix_row,
  input  logic [COL_W-1:0]         pix_col,
  input  logic [PIX_W-1:0]         pixel_value,
  input  logic [CIDX_W-1:0]        coef_index,
  input  logic signed [COEF_W-1:0] coef_value,
  output logic                     result_valid,
  output logic [ROW_W-1:0]         out_row,
  output logic [COL_W-1:0]         out_col,
  output logic signed [OUT_W-1:0]  filtered,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  logic [CNT_W-1:0] image_rows;
  logic [CNT_W-1:0] image_cols;
  logic             mirror_mode;
  logic             cfg_wr;

  imcc_cmd_t  cmd;
  imcc_stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows  <= CNT_W'(MAX_ROWS);
      image_cols  <= CNT_W'(MAX_COLS);
      mirror_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ROWS:   image_rows  <= pwdata[CNT_W-1:0];
        REG_COLS:   image_cols  <= pwdata[CNT_W-1:0];
        REG_MIRROR: mirror_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS:   prdata = PDATA_W'(image_rows);
      REG_COLS:   prdata = PDATA_W'(image_cols);
      REG_MIRROR: prdata = PDATA_W'(mirror_mode);
      default:    prdata = '0;
    endcase
  end

  imcc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .op   (op),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  imcc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .image_rows  (image_rows),
    .image_cols  (image_cols),
    .mirror_mode (mirror_mode),
    .pix_row     (pix_row),
    .pix_col     (pix_col),
    .pixel_value (pixel_value),
    .coef_index  (coef_index),
    .coef_value  (coef_value),
    .result_valid(result_valid),
    .out_row     (out_row),
    .out_col     (out_col),
    .filtered    (filtered)
  );

endmodule

@@ src/imcc_ctrl.sv @@
// Controller FSM: accepts transactions, walks the mask taps, waits for drain.
// Depends on imcc_pkg and the assertion macro header.
`include "image_mask_correlate_convolve_top_defines.svh"

module imcc_ctrl
  import imcc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [OP_W-1:0] op,
  input  imcc_stat_t      stat,
  output imcc_cmd_t       cmd,
  output logic            busy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(MASK_SIZE - 1);

  state_t           state;
  logic [TAP_W-1:0] tap_r;
  logic [TAP_W-1:0] tap_c;
  logic             accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    cmd         = '0;
    cmd.coef_we = accept && (op == OP_LOAD_COEF);
    cmd.pix_we  = accept && (op == OP_WRITE_PIX);
    cmd.capture = accept && (op == OP_COMPUTE);
    cmd.issue   = (state == ST_RUN);
    cmd.first   = (tap_r == '0) && (tap_c == '0);
    cmd.last    = (tap_r == TAP_LAST) && (tap_c == TAP_LAST);
    cmd.tap_r   = tap_r;
    cmd.tap_c   = tap_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tap_r <= '0;
      tap_c <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          tap_r <= '0;
          tap_c <= '0;
          if (accept && (op == OP_COMPUTE)) state <= ST_RUN;
        end
        ST_RUN: begin
          if (tap_c == TAP_LAST) begin
            tap_c <= '0;
            if (tap_r == TAP_LAST) begin
              tap_r <= '0;
              state <= ST_DRAIN;
            end else begin
              tap_r <= tap_r + 1'b1;
            end
          end else begin
            tap_c <= tap_c + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (stat.drain_done) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `IMCC_ASSERT_NXT(a_compute_starts_walk, cmd.capture, cmd.issue && cmd.first)
  `IMCC_ASSERT_NXT(a_last_tap_drains, cmd.issue && cmd.last, state == ST_DRAIN)
  `IMCC_ASSERT_IMP(a_no_accept_while_busy, busy, !cmd.coef_we && !cmd.pix_we && !cmd.capture)

endmodule

@@ src/imcc_datapath.sv @@
// Datapath: frame memory, coefficient registers, clamped address generation,
// multiply and accumulate pipeline, result registers.
// Depends on imcc_pkg and the assertion macro header.
`include "image_mask_correlate_convolve_top_defines.svh"

module imcc_datapath
  import imcc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  imcc_cmd_t                cmd,
  output imcc_stat_t               stat,
  input  logic [CNT_W-1:0]         image_rows,
  input  logic [CNT_W-1:0]         image_cols,
  input  logic                     mirror_mode,
  input  logic [ROW_W-1:0]         pix_row,
  input  logic [COL_W-1:0]         pix_col,
  input  logic [PIX_W-1:0]         pixel_value,
  input  logic [CIDX_W-1:0]        coef_index,
  input  logic signed [COEF_W-1:0] coef_value,
  output logic                     result_valid,
  output logic [ROW_W-1:0]         out_row,
  output logic [COL_W-1:0]         out_col,
  output logic signed [OUT_W-1:0]  filtered
);

  logic [PIXEL_BITS-1:0]    pix_mem [MEM_DEPTH];
  logic signed [COEF_W-1:0] coef [MASK_LEN];

  logic [ROW_W-1:0] req_row;
  logic [COL_W-1:0] req_col;

  logic [CNT_W-1:0] nr;
  logic [CNT_W-1:0] nc;
  logic             wr_ok;

  logic signed [SW-1:0] dr;
  logic signed [SW-1:0] dc;
  logic signed [SW-1:0] r_raw;
  logic signed [SW-1:0] c_raw;
  logic [ROW_W-1:0]     r_cl;
  logic [COL_W-1:0]     c_cl;
  logic [CIDX_W-1:0]    k_idx;

  logic                     rd_vld;
  logic                     rd_first;
  logic                     rd_last;
  logic [PIXEL_BITS-1:0]    rd_pix;
  logic signed [COEF_W-1:0] rd_coef;

  logic                     prod_vld;
  logic                     prod_first;
  logic                     prod_last;
  logic signed [PROD_W-1:0] prod;

  logic signed [OUT_W-1:0] acc;
  logic signed [OUT_W-1:0] prod_ext;
  logic signed [OUT_W-1:0] sum;

  always_comb begin
    if (image_rows == '0) nr = CNT_W'(1);
    else if (image_rows > CNT_W'(MAX_ROWS)) nr = CNT_W'(MAX_ROWS);
    else nr = image_rows;
    if (image_cols == '0) nc = CNT_W'(1);
    else if (image_cols > CNT_W'(MAX_COLS)) nc = CNT_W'(MAX_COLS);
    else nc = image_cols;
  end

  assign wr_ok = ({1'b0, pix_row} < nr) && ({1'b0, pix_col} < nc);

  always_comb begin
    dr = $signed({{(SW-TAP_W){1'b0}}, cmd.tap_r}) - SW'(MASK_HALF);
    dc = $signed({{(SW-TAP_W){1'b0}}, cmd.tap_c}) - SW'(MASK_HALF);
    r_raw = mirror_mode ? ($signed({2'b00, req_row}) - dr) : ($signed({2'b00, req_row}) + dr);
    c_raw = mirror_mode ? ($signed({2'b00, req_col}) - dc) : ($signed({2'b00, req_col}) + dc);
    if (r_raw < 0) r_cl = '0;
    else if (r_raw >= $signed({1'b0, nr})) r_cl = ROW_W'(nr - 1'b1);
    else r_cl = r_raw[ROW_W-1:0];
    if (c_raw < 0) c_cl = '0;
    else if (c_raw >= $signed({1'b0, nc})) c_cl = COL_W'(nc - 1'b1);
    else c_cl = c_raw[COL_W-1:0];
    k_idx = CIDX_W'(cmd.tap_r * MASK_SIZE) + CIDX_W'(cmd.tap_c);
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_we && wr_ok) begin
      pix_mem[{pix_row, pix_col}] <= pixel_value[PIXEL_BITS-1:0];
    end
    if (cmd.issue) begin
      rd_pix <= pix_mem[{r_cl, c_cl}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_we && (coef_index < CIDX_W'(MASK_LEN))) begin
      coef[coef_index[KW-1:0]] <= coef_value;
    end
    if (cmd.capture) begin
      req_row <= pix_row;
      req_col <= pix_col;
    end
    if (cmd.issue) begin
      rd_coef  <= coef[k_idx[KW-1:0]];
      rd_first <= cmd.first;
      rd_last  <= cmd.last;
    end
    if (rd_vld) begin
      prod       <= rd_coef * $signed({1'b0, rd_pix});
      prod_first <= rd_first;
      prod_last  <= rd_last;
    end
    if (prod_vld) begin
      acc <= sum;
    end
    if (prod_vld && prod_last) begin
      filtered <= sum;
      out_row  <= req_row;
      out_col  <= req_col;
    end
  end

  assign prod_ext = OUT_W'(prod);
  assign sum      = prod_first ? prod_ext : (acc + prod_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld       <= 1'b0;
      prod_vld     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_vld       <= cmd.issue;
      prod_vld     <= rd_vld;
      result_valid <= prod_vld && prod_last;
    end
  end

  assign stat.drain_done = prod_vld && prod_last;

  `IMCC_ASSERT_NXT(a_strobe_single, result_valid, !result_valid)
  `IMCC_ASSERT_IMP(a_strobe_after_last, result_valid, $past(prod_vld && prod_last))
  `IMCC_ASSERT_IMP(a_first_on_empty_pipe, cmd.issue && cmd.first, !rd_vld && !prod_vld)

endmodule
